>>> src/fidr_pkg.sv
// shared types, codes and constants of the fock integral digest block
package fidr_pkg;

    // input commands
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_DIGEST = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // configuration register indexes
    localparam logic [1:0] CFG_EXCHANGE   = 2'd0;
    localparam logic [1:0] CFG_LONG_RANGE = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd2;
    localparam logic [1:0] CFG_ACTIVE     = 2'd3;

    // configuration reset values
    localparam logic [17:0] RST_EXCHANGE   = 18'h30000;
    localparam logic [17:0] RST_LONG_RANGE = 18'h00000;
    localparam logic [31:0] RST_THRESHOLD  = 32'd1;
    localparam logic [2:0]  RST_ACTIVE     = 3'd1;

    // sequencer states
    typedef enum logic [4:0] {
        ST_BOOT_CLR, ST_IDLE, ST_DISPATCH, ST_LOAD, ST_RD, ST_RD_CAP, ST_CLEAR,
        ST_SCR, ST_SCR_CHK, ST_EXC, ST_EXC_CAP, ST_VEC, ST_DRD, ST_DGET, ST_CMUL,
        ST_CCAP, ST_FRD, ST_FWR, ST_XRD, ST_XMUL, ST_XWR, ST_VNEXT, ST_DONE
    } t_state;

    // datapath operations
    typedef enum logic [4:0] {
        DP_NONE, DP_CAPTURE, DP_LOAD, DP_RD_CMD, DP_RES_FV, DP_CLR, DP_MUL_SCR,
        DP_SCR_CHK, DP_MUL_EXC, DP_CAP_EXC, DP_DRD, DP_DGET, DP_MUL_C, DP_CAP_C,
        DP_FRD, DP_FWR, DP_XRD, DP_MUL_X, DP_XWR, DP_PUSH
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [3:0] step;
        logic [3:0] vec;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic       skip;
        logic       screened;
        logic       kind;
        logic       ratio_nz;
        logic [4:0] nv;
        logic       clr_last;
        logic       out_free;
    } t_dp_stat;

    // exchange updates: fock row, fock col, density row, density col (0 i, 1 j, 2 k, 3 l)
    localparam logic [1:0] XCHG_MAP [16][4] = '{
        '{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd1, 2'd2}, '{2'd0, 2'd3, 2'd2, 2'd1},
        '{2'd2, 2'd1, 2'd0, 2'd3}, '{2'd1, 2'd2, 2'd3, 2'd0},
        '{2'd3, 2'd1, 2'd0, 2'd2}, '{2'd1, 2'd3, 2'd2, 2'd0},
        '{2'd0, 2'd2, 2'd1, 2'd3}, '{2'd2, 2'd0, 2'd3, 2'd1},
        '{2'd3, 2'd0, 2'd2, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2},
        '{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd1, 2'd2, 2'd0, 2'd3},
        '{2'd3, 2'd1, 2'd2, 2'd0}, '{2'd1, 2'd3, 2'd0, 2'd2}
    };

endpackage

>>> src/fock_integral_digest_restricted_unit.sv
// top level of the fock integral digest block
// Keeps density and Fock matrices for up to VECTORS trial vectors of BASIS x BASIS
// elements in two single-port memories, plus the running largest absolute density.
// Items are handled one at a time; the input is taken again while a result waits
// in the output register. A digest first makes the screening decision, then the
// exchange factor, then per active vector does Coulomb work (full integrals),
// exchange work when the ratio is nonzero and vector bookkeeping; its pace is set
// by the read-modify-write steps on the Fock memory and the one shared multiplier.
// A clear sweeps the Fock memory one entry a cycle over VECTORS times BASIS^2
// entries, each rounded up to a power of two (16384 by default); the same sweep
// runs after reset, during which no item is taken.
module fock_integral_digest_restricted_unit
    import fidr_pkg::*;
#(
    parameter int BASIS   = 64,
    parameter int VECTORS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // index_i, index_j, index_k, index_l, value, bound
    input  logic [87:0] s_tdata,
    // command, vector_sel, integral_kind
    input  logic [4:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // fock_value
    output logic [47:0] m_tdata,
    // screened
    output logic [0:0]  m_tuser
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    fidr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    fidr_dpath #(
        .BASIS   (BASIS),
        .VECTORS (VECTORS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

>>> src/fidr_ctrl.sv
// sequencer of the fock integral digest block
module fidr_ctrl
    import fidr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;
    logic [3:0] r_vec, n_vec;
    logic       w_last_vec;

    assign w_last_vec = ({1'b0, r_vec} + 5'd1) == i_stat.nv;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BOOT_CLR;
            r_step  <= '0;
            r_vec   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_vec   <= n_vec;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_vec   = r_vec;
        case (r_state)
            ST_BOOT_CLR: if (i_stat.clr_last) n_state = ST_IDLE;
            ST_IDLE:     if (i_s_tvalid) n_state = ST_DISPATCH;
            ST_DISPATCH: begin
                n_vec  = '0;
                n_step = '0;
                case (i_stat.cmd)
                    CMD_LOAD:   n_state = ST_LOAD;
                    CMD_READ:   n_state = ST_RD;
                    CMD_CLEAR:  n_state = ST_CLEAR;
                    CMD_DIGEST: n_state = i_stat.skip ? ST_DONE : ST_SCR;
                    default:    n_state = ST_DONE;
                endcase
            end
            ST_LOAD:    n_state = ST_DONE;
            ST_RD:      n_state = ST_RD_CAP;
            ST_RD_CAP:  n_state = ST_DONE;
            ST_CLEAR:   if (i_stat.clr_last) n_state = ST_DONE;
            ST_SCR:     n_state = ST_SCR_CHK;
            ST_SCR_CHK: n_state = i_stat.screened ? ST_DONE : ST_EXC;
            ST_EXC:     n_state = ST_EXC_CAP;
            ST_EXC_CAP: n_state = (i_stat.nv == 5'd0) ? ST_DONE : ST_VEC;
            ST_VEC: begin
                n_step  = '0;
                n_state = i_stat.kind ? ST_XRD : ST_DRD;
            end
            ST_DRD:     n_state = ST_DGET;
            ST_DGET: begin
                if (r_step[0]) begin
                    n_state = ST_CMUL;
                end else begin
                    n_step  = r_step + 4'd1;
                    n_state = ST_DRD;
                end
            end
            ST_CMUL:    n_state = ST_CCAP;
            ST_CCAP: begin
                if (r_step == 4'd3) begin
                    n_step  = '0;
                    n_state = ST_FRD;
                end else begin
                    n_step  = r_step + 4'd1;
                    n_state = ST_DRD;
                end
            end
            ST_FRD:     n_state = ST_FWR;
            ST_FWR: begin
                if (r_step == 4'd3) begin
                    n_step  = '0;
                    n_state = i_stat.ratio_nz ? ST_XRD : ST_VNEXT;
                end else begin
                    n_step  = r_step + 4'd1;
                    n_state = ST_FRD;
                end
            end
            ST_XRD:     n_state = ST_XMUL;
            ST_XMUL:    n_state = ST_XWR;
            ST_XWR: begin
                n_step = r_step + 4'd1;
                if (r_step == 4'd15) n_state = ST_VNEXT;
                else n_state = ST_XRD;
            end
            ST_VNEXT: begin
                if (w_last_vec) begin
                    n_state = ST_DONE;
                end else begin
                    n_vec   = r_vec + 4'd1;
                    n_state = ST_VEC;
                end
            end
            ST_DONE:    if (i_stat.out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd.op   = DP_NONE;
        o_cmd.step = r_step;
        o_cmd.vec  = r_vec;
        case (r_state)
            ST_BOOT_CLR: o_cmd.op = DP_CLR;
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) o_cmd.op = DP_CAPTURE;
            end
            ST_LOAD:    o_cmd.op = DP_LOAD;
            ST_RD:      o_cmd.op = DP_RD_CMD;
            ST_RD_CAP:  o_cmd.op = DP_RES_FV;
            ST_CLEAR:   o_cmd.op = DP_CLR;
            ST_SCR:     o_cmd.op = DP_MUL_SCR;
            ST_SCR_CHK: o_cmd.op = DP_SCR_CHK;
            ST_EXC:     o_cmd.op = DP_MUL_EXC;
            ST_EXC_CAP: o_cmd.op = DP_CAP_EXC;
            ST_DRD:     o_cmd.op = DP_DRD;
            ST_DGET:    o_cmd.op = DP_DGET;
            ST_CMUL:    o_cmd.op = DP_MUL_C;
            ST_CCAP:    o_cmd.op = DP_CAP_C;
            ST_FRD:     o_cmd.op = DP_FRD;
            ST_FWR:     o_cmd.op = DP_FWR;
            ST_XRD:     o_cmd.op = DP_XRD;
            ST_XMUL:    o_cmd.op = DP_MUL_X;
            ST_XWR:     o_cmd.op = DP_XWR;
            ST_DONE:    if (i_stat.out_free) o_cmd.op = DP_PUSH;
            default:    o_cmd.op = DP_NONE;
        endcase
    end

endmodule

>>> src/fidr_dpath.sv
// datapath of the fock integral digest block: stores, multiplier, accumulate
module fidr_dpath
    import fidr_pkg::*;
#(
    parameter int BASIS   = 64,
    parameter int VECTORS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic [87:0] i_s_tdata,
    input  logic [4:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,
    output logic [0:0]  o_m_tuser,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat
);

    localparam int IW     = (BASIS > 1) ? $clog2(BASIS) : 1;
    localparam int VW     = (VECTORS > 1) ? $clog2(VECTORS) : 1;
    localparam int AW     = VW + 2 * IW;
    localparam int DEPTH  = 1 << AW;

    // configuration
    logic [17:0] r_exch, r_lr;
    logic [31:0] r_thr;
    logic [2:0]  r_act;

    // captured item
    t_cmd         r_cmd;
    logic [1:0]   r_vs;
    logic [5:0]   r_idx [4];
    logic [31:0]  r_val;
    logic [31:0]  r_bound;
    logic         r_kind;

    // working registers
    logic [31:0]         r_maxd;
    logic signed [67:0]  r_prod;
    logic signed [34:0]  r_exc;
    logic signed [32:0]  r_d;
    logic signed [48:0]  r_c1, r_c2;
    logic [1:0]          r_s;
    logic [AW-1:0]       r_clr;
    logic [47:0]         r_res_fv;
    logic                r_res_scr;
    logic                r_ovalid;
    logic [47:0]         r_ofv;
    logic                r_oscr;

    // stores
    logic [31:0] r_dmem [DEPTH];
    logic [47:0] r_fmem [DEPTH];
    logic [31:0] r_dq;
    logic [47:0] r_fq;

    logic [IW-1:0]      w_ix [4];
    logic [VW-1:0]      w_vs, w_vec;
    logic               w_ld_ok, w_in_range;
    logic [17:0]        w_ratio;
    logic [31:0]        w_mag;
    logic signed [34:0] w_ma;
    logic signed [32:0] w_mb;
    logic [AW-1:0]      w_cmd_addr, w_daddr, w_faddr;
    logic               w_dre, w_dwe, w_fre, w_fwe;
    logic [47:0]        w_fwd;
    logic signed [48:0] w_term;
    logic signed [67:0] w_sh;
    logic [1:0]         w_da, w_db, w_fa, w_fb;

    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic signed [48:0] t);
        logic signed [48:0] s;
        s = $signed({a[47], a}) + t;
        if (s[48] != s[47]) sat_add = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else sat_add = s[47:0];
    endfunction

    // index truncation and range checks
    always_comb begin
        w_in_range = 1'b1;
        for (int n = 0; n < 4; n++) begin
            w_ix[n] = IW'(r_idx[n]);
            if ({3'd0, r_idx[n]} >= 9'(BASIS)) w_in_range = 1'b0;
        end
    end
    assign w_vs    = VW'(r_vs);
    assign w_vec   = VW'(i_cmd.vec);
    assign w_ld_ok = ({3'd0, r_vs} < 5'(VECTORS)) && ({3'd0, r_idx[0]} < 9'(BASIS)) &&
                     ({3'd0, r_idx[1]} < 9'(BASIS));
    assign w_ratio = r_kind ? r_lr : r_exch;
    assign w_mag   = r_val[31] ? (32'd0 - r_val) : r_val;
    assign w_cmd_addr = {w_vs, w_ix[0], w_ix[1]};

    // status
    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.skip     = !w_in_range || (r_kind && (r_lr == 18'd0));
        o_stat.screened = r_prod[63:0] < {8'd0, r_thr, 24'd0};
        o_stat.kind     = r_kind;
        o_stat.ratio_nz = w_ratio != 18'd0;
        o_stat.nv       = ({2'd0, r_act} > 5'(VECTORS)) ? 5'(VECTORS) : {2'd0, r_act};
        o_stat.clr_last = r_clr == {AW{1'b1}};
        o_stat.out_free = !r_ovalid || i_m_tready;
    end

    // address selection for coulomb and exchange steps
    always_comb begin
        case (i_cmd.step[1:0])
            2'd0:    begin w_da = 2'd2; w_db = 2'd3; end
            2'd1:    begin w_da = 2'd3; w_db = 2'd2; end
            2'd2:    begin w_da = 2'd0; w_db = 2'd1; end
            default: begin w_da = 2'd1; w_db = 2'd0; end
        endcase
        w_fa = w_da ^ 2'd2;
        w_fb = w_db ^ 2'd2;
        if (i_cmd.op == DP_XRD || i_cmd.op == DP_XWR) begin
            w_fa = XCHG_MAP[i_cmd.step][0];
            w_fb = XCHG_MAP[i_cmd.step][1];
            w_da = XCHG_MAP[i_cmd.step][2];
            w_db = XCHG_MAP[i_cmd.step][3];
        end
    end

    // memory controls
    always_comb begin
        w_dre   = (i_cmd.op == DP_DRD) || (i_cmd.op == DP_XRD);
        w_dwe   = (i_cmd.op == DP_LOAD) && w_ld_ok;
        w_daddr = w_dwe ? w_cmd_addr : {w_vec, w_ix[w_da], w_ix[w_db]};
        w_fre   = (i_cmd.op == DP_RD_CMD) || (i_cmd.op == DP_FRD) || (i_cmd.op == DP_XRD);
        w_fwe   = (i_cmd.op == DP_CLR) || (i_cmd.op == DP_FWR) || (i_cmd.op == DP_XWR);
        w_term  = (i_cmd.op == DP_XWR) ? w_sh[48:0] : (i_cmd.step[1] ? r_c2 : r_c1);
        w_fwd   = (i_cmd.op == DP_CLR) ? 48'd0 : sat_add(r_fq, w_term);
        if (i_cmd.op == DP_CLR) w_faddr = r_clr;
        else if (i_cmd.op == DP_RD_CMD) w_faddr = w_cmd_addr;
        else w_faddr = {w_vec, w_ix[w_fa], w_ix[w_fb]};
    end

    // density store
    always_ff @(posedge i_clk) begin
        if (w_dwe) r_dmem[w_daddr] <= r_val;
        if (w_dre) r_dq <= r_dmem[w_daddr];
    end

    // fock store
    always_ff @(posedge i_clk) begin
        if (w_fwe) r_fmem[w_faddr] <= w_fwd;
        if (w_fre) r_fq <= r_fmem[w_faddr];
    end

    // shared multiplier operands
    always_comb begin
        case (i_cmd.op)
            DP_MUL_SCR: begin w_ma = {3'd0, r_maxd}; w_mb = {1'b0, r_bound}; end
            DP_MUL_EXC: begin
                w_ma = {{3{r_val[31]}}, r_val};
                w_mb = {{15{w_ratio[17]}}, w_ratio};
            end
            DP_MUL_X:   begin w_ma = r_exc; w_mb = {r_dq[31], r_dq}; end
            default:    begin w_ma = {{3{r_val[31]}}, r_val}; w_mb = r_d; end
        endcase
        w_sh = r_prod >>> 24;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exch <= RST_EXCHANGE;
            r_lr   <= RST_LONG_RANGE;
            r_thr  <= RST_THRESHOLD;
            r_act  <= RST_ACTIVE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXCHANGE:   r_exch <= i_cfg_data[17:0];
                CFG_LONG_RANGE: r_lr   <= i_cfg_data[17:0];
                CFG_THRESHOLD:  r_thr  <= i_cfg_data;
                CFG_ACTIVE:     r_act  <= i_cfg_data[2:0];
                default:        r_act  <= r_act;
            endcase
        end
    end

    // control state: max density, clear sweep, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxd   <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == DP_LOAD && w_ld_ok && w_mag > r_maxd) r_maxd <= w_mag;
            if (i_cmd.op == DP_CLR) r_clr <= r_clr + AW'(1);
            if (i_cmd.op == DP_PUSH) r_ovalid <= 1'b1;
            else if (i_m_tready) r_ovalid <= 1'b0;
        end
    end

    // item capture and arithmetic registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_CAPTURE: begin
                r_cmd     <= t_cmd'(i_s_tuser[1:0]);
                r_vs      <= i_s_tuser[3:2];
                r_kind    <= i_s_tuser[4];
                r_idx[0]  <= i_s_tdata[5:0];
                r_idx[1]  <= i_s_tdata[11:6];
                r_idx[2]  <= i_s_tdata[17:12];
                r_idx[3]  <= i_s_tdata[23:18];
                r_val     <= i_s_tdata[55:24];
                r_bound   <= i_s_tdata[87:56];
                r_res_fv  <= '0;
                r_res_scr <= 1'b0;
            end
            DP_RES_FV:  r_res_fv <= w_ld_ok ? r_fq : 48'd0;
            DP_MUL_SCR: r_prod <= w_ma * w_mb;
            DP_SCR_CHK: begin
                r_res_scr <= o_stat.screened;
                r_s <= 2'(r_idx[0] == r_idx[1]) + 2'(r_idx[2] == r_idx[3]) +
                       2'((r_idx[0] == r_idx[2]) && (r_idx[1] == r_idx[3]));
            end
            DP_MUL_EXC, DP_MUL_C, DP_MUL_X: r_prod <= w_ma * w_mb;
            DP_CAP_EXC: r_exc <= 35'(r_prod >>> (7'd16 + 7'(r_s)));
            DP_DGET: begin
                if (i_cmd.step[0]) r_d <= r_d + $signed({r_dq[31], r_dq});
                else r_d <= $signed({r_dq[31], r_dq});
            end
            DP_CAP_C: begin
                if (i_cmd.step[1]) r_c2 <= 49'(r_prod >>> (7'd22 + 7'(r_s)));
                else r_c1 <= 49'(r_prod >>> (7'd22 + 7'(r_s)));
            end
            DP_PUSH: begin
                r_ofv  <= r_res_fv;
                r_oscr <= r_res_scr;
            end
            default: r_s <= r_s;
        endcase
    end

    assign o_m_tvalid   = r_ovalid;
    assign o_m_tdata    = r_ofv;
    assign o_m_tuser[0] = r_oscr;

endmodule
